// File: design/assert_macros.svh
// Assertion macros for the substring search RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FSUB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define FSUB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define FSUB_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`else
`define FSUB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FSUB_ASSERT_NEXT(label, clk, rst, ante, cons)
`define FSUB_ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

// File: design/fsub_pkg.sv
// Types and constants for the first substring match block.
// No dependencies; used by every module of the block.
package fsub_pkg;

   localparam int DEF_MAX_NEEDLE    = 16;
   localparam int DEF_POSITION_BITS = 32;

   localparam int NEEDLE_BYTES     = 16;
   localparam int LEN_BITS         = 5;
   localparam int MATCH_START_BITS = 32;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH = 2'd2;

   typedef struct packed {
      logic [7:0] hay_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic [MATCH_START_BITS-1:0] match_start;
   } rsp_type;

   typedef struct packed {
      logic [NEEDLE_BYTES-1:0][7:0] needle;
      logic [LEN_BITS-1:0]          needle_length;
   } needle_cfg_type;

endpackage

// File: design/fsub_csr.sv
// Configuration registers: needle bytes and needle length.
// Depends on fsub_pkg.
module fsub_csr
   import fsub_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output needle_cfg_type            cfg
);

   needle_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NEEDLE_LOW:    cfg_in.needle[7:0]    = csr_wdata;
            CSR_NEEDLE_HIGH:   cfg_in.needle[15:8]   = csr_wdata;
            CSR_NEEDLE_LENGTH: cfg_in.needle_length  = csr_wdata[LEN_BITS-1:0];
            default:           cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: design/fsub_match.sv
// Byte history, counters and the parallel needle compare for one item.
// Depends on fsub_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fsub_match
   import fsub_pkg::*;
#(
   parameter int MAX_NEEDLE    = DEF_MAX_NEEDLE,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  req_type        item,
   input  needle_cfg_type cfg,
   output logic           res_valid,
   output rsp_type        result
);

   localparam int WIN_DEPTH = (MAX_NEEDLE > 1) ? MAX_NEEDLE - 1 : 1;
   localparam int SEEN_BITS = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
   localparam int EXT_BITS  = (POSITION_BITS > MATCH_START_BITS) ?
                              POSITION_BITS : MATCH_START_BITS;
   localparam logic [SEEN_BITS-1:0]     SEEN_MAX = SEEN_BITS'(MAX_NEEDLE - 1);
   localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;

   logic [WIN_DEPTH-1:0][7:0]     window_ff, window_in;
   logic [SEEN_BITS-1:0]          seen_ff, seen_in;
   logic [POSITION_BITS-1:0]      pos_ff, pos_in;
   logic                          done_ff, done_in;

   logic [LEN_BITS-1:0]           len, len_m1;
   logic [MAX_NEEDLE-1:0][7:0]    seq;
   logic [MAX_NEEDLE-1:0][3:0]    nidx;
   logic [MAX_NEEDLE-1:0]         eq;
   logic                          enough;
   logic                          hit;
   logic [POSITION_BITS-1:0]      start;
   logic [EXT_BITS-1:0]           start_ext;

   assign len    = (cfg.needle_length > LEN_BITS'(MAX_NEEDLE)) ?
                   LEN_BITS'(MAX_NEEDLE) : cfg.needle_length;
   assign len_m1 = len - LEN_BITS'(1);

   always_comb begin
      seq[0] = item.hay_byte;
      for (int k = 1; k < MAX_NEEDLE; k++) begin
         seq[k] = window_ff[k-1];
      end
      for (int k = 0; k < MAX_NEEDLE; k++) begin
         nidx[k] = 4'(len_m1 - LEN_BITS'(k));
         eq[k]   = (LEN_BITS'(k) >= len) || (seq[k] == cfg.needle[nidx[k]]);
      end
   end

   assign enough = (LEN_BITS'(seen_ff) + LEN_BITS'(1)) >= len;
   assign hit    = (len == '0) || (enough && (&eq));

   assign start     = (len == '0) ? '0 : pos_ff - POSITION_BITS'(len_m1);
   assign start_ext = EXT_BITS'(start);

   assign res_valid          = !done_ff && (hit || item.final_byte);
   assign result.found       = hit;
   assign result.match_start = hit ? start_ext[MATCH_START_BITS-1:0] : '0;

   always_comb begin
      window_in    = window_ff;
      window_in[0] = item.hay_byte;
      for (int k = 1; k < WIN_DEPTH; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   always_comb begin
      if (item.final_byte) begin
         seen_in = '0;
         pos_in  = '0;
         done_in = 1'b0;
      end else begin
         seen_in = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + SEEN_BITS'(1);
         pos_in  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POSITION_BITS'(1);
         done_in = done_ff || hit;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else if (step) begin
         seen_ff <= seen_in;
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   `FSUB_ASSERT_NEXT(a_final_clears, clock, reset, step && item.final_byte, (pos_ff == '0) && (seen_ff == '0) && !done_ff)
   `FSUB_ASSERT_NEXT(a_hit_sets_done, clock, reset, step && hit && !item.final_byte, done_ff)
   `FSUB_ASSERT_IMPL(a_done_quiet, clock, reset, done_ff, !res_valid)
   `FSUB_ASSERT_ALWAYS(a_pos_covers_seen, clock, reset, pos_ff >= POSITION_BITS'(seen_ff))

endmodule

// File: design/first_substring_match.sv
// Streaming first substring match: one haystack byte per item, needle up to 16 bytes.
// An accepted item is held in the input register; its result is registered into the output register when it advances.
// Throughput: one item per cycle while rsp_ready is high; the combinational window compare sets it.
// Reset (synchronous, active high) clears the needle registers, counters and valid flags.
// Depends on fsub_pkg, fsub_csr and fsub_match.
module first_substring_match
   import fsub_pkg::*;
#(
   parameter int MAX_NEEDLE    = DEF_MAX_NEEDLE,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   needle_cfg_type cfg;
   logic           in_valid_ff, in_valid_in;
   req_type        in_item_ff;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_item_ff;
   logic           advance;
   logic           res_valid;
   rsp_type        result;

   assign csr_ready = 1'b1;

   fsub_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fsub_match #(
      .MAX_NEEDLE    (MAX_NEEDLE),
      .POSITION_BITS (POSITION_BITS)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (in_item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .result    (result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance ? res_valid : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// File: tb/sv/first_substring_match_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for first_substring_match: a directed table, then random haystacks
// built around configured needles, each result checked against a search model held here.
// Depends on fsub_pkg and the first_substring_match RTL.
module first_substring_match_tb;
   import fsub_pkg::*;

   localparam int CLEAR_CYCLES = 6;
   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_TARGET = 1700;
   localparam int WINDOW_DEPTH = NEEDLE_BYTES - 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {ROW_REG, ROW_BYTE} row_kind_type;
   typedef enum logic [1:0] {ANS_PREDICT, ANS_NONE, ANS_GIVEN} answer_src_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  wdata;
      logic [7:0]                hay;
      logic                      fin;
      answer_src_type            src;
      logic                      found;
      logic [31:0]               start;
   } script_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic [63:0] needle_lo = '0;
   logic [63:0] needle_hi = '0;
   logic [4:0]  needle_len = '0;
   logic [7:0]  hay_window [WINDOW_DEPTH] = '{default: 8'h00};
   int          window_fill = 0;
   logic [31:0] hay_offset = '0;
   logic        match_reported = 1'b0;

   rsp_type     results_due [$];
   rsp_type     head;
   int unsigned failures = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   bit          narrow = 1'b0;
   logic [7:0]  alpha_base = '0;

   script_row_type script [26] = '{
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b0, ANS_GIVEN, 1'b1, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'hFF, 1'b1, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h5A, 1'b1, ANS_GIVEN, 1'b1, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LOW, 64'h4241, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LENGTH, 64'd2, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h41, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h42, 1'b0, ANS_GIVEN, 1'b1, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h43, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b1, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h42, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h41, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h41, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h42, 1'b1, ANS_GIVEN, 1'b1, 32'd2},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h41, 1'b1, ANS_GIVEN, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LOW, 64'hFF, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LENGTH, 64'd1, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'hFF, 1'b0, ANS_GIVEN, 1'b1, 32'd1},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'hFF, 1'b1, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_REG, CSR_NEEDLE_LENGTH, 64'd31, 8'h00, 1'b0, ANS_NONE, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'hFF, 1'b0, ANS_PREDICT, 1'b0, 32'd0},
      '{ROW_BYTE, CSR_NEEDLE_LOW, 64'd0, 8'h00, 1'b1, ANS_GIVEN, 1'b0, 32'd0}
   };

   first_substring_match dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit calm();
      return items_sent >= 700 && items_sent < 1000;
   endfunction

   function automatic logic [7:0] needle_byte(input int k);
      return (k < 8) ? needle_lo[8*k +: 8] : needle_hi[8*(k-8) +: 8];
   endfunction

   function automatic logic [7:0] pick_byte();
      if (narrow && $urandom_range(0, 9) != 0) begin
         return alpha_base + 8'($urandom_range(0, 3));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_NEEDLE_LOW: needle_lo = val;
         CSR_NEEDLE_HIGH: needle_hi = val;
         CSR_NEEDLE_LENGTH: needle_len = val[4:0];
         default: ;
      endcase
   endfunction

   task automatic search_step(input logic [7:0] b, input logic fin,
                              output bit got, output rsp_type predicted);
      int   span;
      int   k;
      logic hit;
      span = (needle_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len);
      got = 1'b0;
      predicted = '0;
      if (!match_reported) begin
         if (span == 0) begin
            hit = 1'b1;
         end else if (window_fill + 1 < span) begin
            hit = 1'b0;
         end else begin
            hit = (needle_byte(span - 1) == b);
            for (k = 1; k < span; k++) begin
               if (hay_window[k-1] != needle_byte(span - 1 - k)) hit = 1'b0;
            end
         end
         if (hit) begin
            predicted.found = 1'b1;
            predicted.match_start = (span == 0) ? 32'd0 : hay_offset - 32'(span - 1);
            match_reported = 1'b1;
            got = 1'b1;
         end else if (fin) begin
            got = 1'b1;
         end
      end
      if (fin) begin
         for (k = 0; k < WINDOW_DEPTH; k++) hay_window[k] = 8'h00;
         window_fill = 0;
         hay_offset = '0;
         match_reported = 1'b0;
      end else begin
         for (k = WINDOW_DEPTH - 1; k > 0; k--) hay_window[k] = hay_window[k-1];
         hay_window[0] = b;
         if (window_fill < WINDOW_DEPTH) window_fill++;
         if (hay_offset != '1) hay_offset++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic fin,
                            input answer_src_type src, input rsp_type given);
      bit      got;
      rsp_type predicted;
      while (!calm() && $urandom_range(0, 99) < 30) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = '{hay_byte: b, final_byte: fin};
      do @(posedge clock); while (!req_ready);
      search_step(b, fin, got, predicted);
      case (src)
         ANS_PREDICT: if (got) results_due.push_back(predicted);
         ANS_GIVEN: results_due.push_back(given);
         default: ;
      endcase
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (CLEAR_CYCLES) @(negedge clock);
   endtask

   task automatic configure_random();
      logic [4:0]  len;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] len_word;
      int          k;
      case ($urandom_range(0, 15))
         0: len = 5'd0;
         1: len = 5'd16;
         2: len = 5'($urandom_range(17, 31));
         3: len = 5'd1;
         default: len = 5'($urandom_range(2, 15));
      endcase
      narrow = $urandom_range(0, 2) != 0;
      alpha_base = 8'($urandom_range(0, 255));
      for (k = 0; k < 8; k++) begin
         lo[8*k +: 8] = pick_byte();
         hi[8*k +: 8] = pick_byte();
      end
      len_word = {32'($urandom), 32'($urandom)};
      if ($urandom_range(0, 3) != 0) len_word[63:5] = '0;
      len_word[4:0] = len;
      if ($urandom_range(0, 3) != 0) write_reg(CSR_NEEDLE_LOW, lo);
      if ($urandom_range(0, 3) != 0) write_reg(CSR_NEEDLE_HIGH, hi);
      write_reg(CSR_NEEDLE_LENGTH, len_word);
      if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE, {32'($urandom), 32'($urandom)});
   endtask

   task automatic feed_haystack(input bit closed);
      logic [7:0] hay [$];
      int         total;
      int         span;
      int         cut;
      int         k;
      total = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
      span = (needle_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len);
      while (hay.size() < total) begin
         case ((span == 0) ? 3 : $urandom_range(0, 3))
            0: begin
               cut = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span - 1) : -1;
               for (k = 0; k < span; k++) begin
                  hay.push_back((k == cut) ? needle_byte(k) ^ 8'($urandom_range(1, 255))
                                           : needle_byte(k));
               end
            end
            1: begin
               cut = $urandom_range(1, span);
               for (k = 0; k < cut; k++) hay.push_back(needle_byte(k));
            end
            default: hay.push_back(pick_byte());
         endcase
      end
      for (k = 0; k < hay.size(); k++) begin
         push_byte(hay[k], closed && k == hay.size() - 1, ANS_PREDICT, '0);
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= calm() || $urandom_range(0, 99) >= 30;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("unexpected result: found %0b, match_start %0d",
                   rsp_data.found, rsp_data.match_start);
            failures++;
         end else begin
            head = results_due.pop_front();
            if (rsp_data.found !== head.found) begin
               $error("found: expected %0b, actual %0b", head.found, rsp_data.found);
               failures++;
            end
            if (rsp_data.match_start !== head.match_start) begin
               $error("match_start: expected %0d, actual %0d",
                      head.match_start, rsp_data.match_start);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("first_substring_match_tb: errors");
         $finish;
      end
   end

   initial begin
      int haystacks;
      int i;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      foreach (script[r]) begin
         if (script[r].kind == ROW_REG) begin
            settle();
            write_reg(script[r].index, script[r].wdata);
         end else begin
            push_byte(script[r].hay, script[r].fin, script[r].src,
                      '{found: script[r].found, match_start: script[r].start});
         end
      end
      while (items_sent < ITEM_TARGET) begin
         settle();
         configure_random();
         haystacks = $urandom_range(1, 4);
         for (i = 0; i < haystacks; i++) begin
            feed_haystack(i < haystacks - 1 || $urandom_range(0, 5) != 0);
         end
      end
      settle();
      if (failures == 0) begin
         $display("first_substring_match_tb: clean");
      end else begin
         $display("first_substring_match_tb: errors");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/fsub_pkg.sv
design/fsub_csr.sv
design/fsub_match.sv
design/first_substring_match.sv
tb/sv/first_substring_match_tb.sv
